/* rtl/core/hpfa_pkg.sv */
// Shared types and constants for the handle pool FIFO allocator.
`timescale 1ns / 1ps

package hpfa_pkg;

    localparam int POOL_DEPTH   = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int PTR_W        = $clog2(POOL_DEPTH);
    localparam int CNT_W        = $clog2(POOL_DEPTH + 1);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RECYCLE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [HANDLE_WIDTH-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [HANDLE_WIDTH-1:0] handle_out;
        logic [CNT_W-1:0]        free_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

/* rtl/core/hpfa_ctrl.sv */
// Sequencing controller for the handle pool allocator.
`timescale 1ns / 1ps

module hpfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output hpfa_pkg::cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        done_next = cmd.execute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* rtl/core/hpfa_dp.sv */
// Datapath: free queue memory, granted-handle set and result register.
`timescale 1ns / 1ps

module hpfa_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  hpfa_pkg::cmd_t cmd,
    input  hpfa_pkg::req_t req,
    output hpfa_pkg::rsp_t rsp
);

    localparam int DEPTH = hpfa_pkg::POOL_DEPTH;
    localparam int HW    = hpfa_pkg::HANDLE_WIDTH;
    localparam int PW    = hpfa_pkg::PTR_W;
    localparam int CW    = hpfa_pkg::CNT_W;

    logic [HW-1:0] fq_mem [DEPTH];

    logic [1:0]    op_reg;
    logic [HW-1:0] handle_reg;
    logic [HW-1:0] cand_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [DEPTH-1:0] gvalid_reg, gvalid_next;
    logic [HW-1:0]    ghandle_reg [DEPTH];

    hpfa_pkg::rsp_t rsp_reg, rsp_next;

    logic [HW-1:0]    key;
    logic [DEPTH-1:0] match;
    logic             hit;
    logic [PW-1:0]    hit_idx;
    logic             has_empty;
    logic [PW-1:0]    empty_idx;
    logic             fq_we;
    logic             g_we;
    logic             q_full;

    assign key    = (op_reg == hpfa_pkg::OP_ALLOC) ? cand_reg : handle_reg;
    assign q_full = (count_reg == CW'(DEPTH));

    // Parallel lookup across the granted set, lowest slot wins
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        has_empty = 1'b0;
        empty_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            match[i] = gvalid_reg[i] && (ghandle_reg[i] == key);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = PW'(i);
            end
            if (!gvalid_reg[i])
            begin
                has_empty = 1'b1;
                empty_idx = PW'(i);
            end
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        gvalid_next = gvalid_reg;
        fq_we       = 1'b0;
        g_we        = 1'b0;
        rsp_next    = rsp_reg;
        if (cmd.execute)
        begin
            rsp_next.status     = hpfa_pkg::ST_OK;
            rsp_next.handle_out = '0;
            case (op_reg)
                hpfa_pkg::OP_LOAD:
                begin
                    if (q_full)
                    begin
                        rsp_next.status = hpfa_pkg::ST_FULL;
                    end
                    else
                    begin
                        fq_we = 1'b1;
                    end
                end
                hpfa_pkg::OP_ALLOC:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = hpfa_pkg::ST_OOM;
                    end
                    else if (!hit && !has_empty)
                    begin
                        rsp_next.status = hpfa_pkg::ST_OOM;
                    end
                    else
                    begin
                        if (!hit)
                        begin
                            g_we                   = 1'b1;
                            gvalid_next[empty_idx] = 1'b1;
                        end
                        rsp_next.handle_out = cand_reg;
                        head_next  = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                hpfa_pkg::OP_RECYCLE:
                begin
                    if (!hit)
                    begin
                        rsp_next.status = hpfa_pkg::ST_INVALID;
                    end
                    else if (q_full)
                    begin
                        rsp_next.status = hpfa_pkg::ST_FULL;
                    end
                    else
                    begin
                        fq_we                = 1'b1;
                        gvalid_next[hit_idx] = 1'b0;
                    end
                end
                default:
                begin
                    rsp_next.status = hpfa_pkg::ST_INVALID;
                end
            endcase
            if (fq_we)
            begin
                tail_next  = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
            rsp_next.free_count = count_next;
        end
    end

    // Free queue storage: one write port at tail, one registered read at head
    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            fq_mem[tail_reg] <= handle_reg;
        end
        if (cmd.capture)
        begin
            cand_reg <= fq_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= req.op;
            handle_reg <= req.handle;
        end
        if (g_we)
        begin
            ghandle_reg[empty_idx] <= cand_reg;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            gvalid_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            gvalid_reg <= gvalid_next;
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("free queue count out of range");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("queue pointers disagree with count");

    a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg == hpfa_pkg::OP_ALLOC
         && rsp_next.status == hpfa_pkg::ST_OK)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("successful allocate did not pop the queue");
`endif

endmodule

/* rtl/core/handle_pool_fifo_allocator.sv */
// Top level of the handle pool FIFO allocator.
`timescale 1ns / 1ps

// Buffer-handle pool with a FIFO free queue of POOL_DEPTH entries.
// Request channel: drive req (op, handle) and raise start; the beat is
// taken on a rising edge where start is high and busy is low.
//   load    - append handle to the free queue (full status when full)
//   alloc   - pop the oldest free handle, record it as granted
//   recycle - return a granted handle to the queue tail
// Response channel: done pulses for exactly one cycle with rsp (status,
// handle_out, free_count); the receiver cannot stall, so the beat is
// taken at the end of that cycle.
// Timing: the accept edge latches the request and reads the queue head
// from memory; the next edge runs the granted-set match and updates state;
// done is high in the cycle after that. busy stays high until the update
// edge, so a new request is not taken before the current one has executed.
// The granted set match is a parallel compare over all slots.
// Reset clears queue pointers, count and granted valid bits; handle
// storage is left undefined and is never read before being written.
module handle_pool_fifo_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  hpfa_pkg::req_t req,
    output logic           done,
    output hpfa_pkg::rsp_t rsp
);

    hpfa_pkg::cmd_t cmd;

    // Sequencer: idle -> execute, and the response strobe
    hpfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Storage, match logic and the registered response
    hpfa_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
